[hdl/dpint_pkg.sv]
// ----------------------------------------------------------------------------
// dpint_pkg: shared types and constants for the particle integrator
// Transaction payloads, item kinds, register indexes and Q16.16 reset values.
// ----------------------------------------------------------------------------
package dpint_pkg;

  // Default number of fraction bits in the fixed-point format
  localparam int FRAC_BITS_DEFAULT = 16;

  // Register index width and codes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ACCEL_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ACCEL_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ACCEL_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE       = 3'd6;

  // Reset values written in Q16.16
  localparam longint Q16_ONE     = 65536;
  localparam longint Q16_GRAVITY = 642908;
  localparam longint Q16_STEP    = 1092;
  localparam longint Q16_DAMP    = 65535;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_FORCE   = 2'd0,
    KIND_STEP    = 2'd1,
    KIND_SET_POS = 2'd2,
    KIND_SET_VEL = 2'd3
  } kind_t;

  // Input transaction payload
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } out_item_t;

  // Scale a non-negative Q16.16 constant to frac fraction bits (truncating)
  function automatic longint rescale_q16(longint v, int frac);
    longint r;
    if (frac >= 16) begin
      r = v <<< (frac - 16);
    end else begin
      r = v >>> (16 - frac);
    end
    return r;
  endfunction

endpackage

[hdl/damped_particle_integrator_unit.sv]
// ----------------------------------------------------------------------------
// damped_particle_integrator_unit: explicit Euler particle integrator
// Holds position, velocity and force sum of one particle in signed fixed
// point and runs damped Euler steps on one shared multiplier and adder.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid / in_stall  | in_data  (in_item_t)
//  out     | output    | out_valid / out_stall| out_data (out_item_t)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
//  Force, set-position, set-velocity and idle steps go through S_OUT to the
//  result register. A live time step works through the axes in turn on the
//  shared 32x32 multiplier and saturating adder, whose product register
//  feeds the next dependent operation of the same axis.
//  The block accepts one item at a time; in_stall is high while it works.
//  A result waiting on out_stall does not block the next item, but the
//  following result waits until the output register is free.
//  rst is synchronous and restores the register defaults and zero state.
module damped_particle_integrator_unit
  import dpint_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // Register defaults at the chosen format
  localparam longint RST_INV_L  = rescale_q16(Q16_ONE, FRAC_BITS);
  localparam longint RST_GRAV_L = -rescale_q16(Q16_GRAVITY, FRAC_BITS);
  localparam longint RST_STEP_L = rescale_q16(Q16_STEP, FRAC_BITS);
  localparam longint RST_DAMP_L = rescale_q16(Q16_DAMP, FRAC_BITS);
  localparam logic [30:0]        RST_INV_MASS = RST_INV_L[30:0];
  localparam logic signed [31:0] RST_ACCEL_Y  = RST_GRAV_L[31:0];
  localparam logic [30:0]        RST_STEP     = RST_STEP_L[30:0];
  localparam logic [16:0]        RST_DAMP     = RST_DAMP_L[16:0];

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_VEL,
    S_POS_FORCE,
    S_ACC,
    S_MUL_ACC,
    S_VEL,
    S_MUL_DAMP,
    S_DAMP,
    S_OUT
  } state_t;

  state_t state;
  logic [1:0] ax;

  // Configuration registers
  logic [30:0]        inv_mass;
  logic signed [31:0] base_accel_x;
  logic signed [31:0] base_accel_y;
  logic signed [31:0] base_accel_z;
  logic [30:0]        time_step;
  logic [16:0]        damping_per_step;
  logic               active;

  // Particle state
  logic signed [31:0] pos_vec [3];
  logic signed [31:0] vel_vec [3];
  logic signed [31:0] force_sum [3];

  // Datapath registers
  logic signed [63:0] prod;
  logic signed [31:0] tmp;

  // Combinational datapath
  logic signed [31:0] vec_in [3];
  logic signed [31:0] force_add [3];
  logic signed [31:0] base_sel;
  logic signed [31:0] mul_a;
  logic [30:0]        mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] prod_shift;
  logic signed [31:0] q_sat;
  logic signed [31:0] add_a;
  logic signed [31:0] sum_sat;
  logic               in_accept;
  logic               out_free;

  function automatic logic signed [31:0] sat33(logic signed [32:0] s);
    logic signed [31:0] r;
    if (s[32] != s[31]) begin
      r = {s[32], {31{~s[32]}}};
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat64(logic signed [63:0] s);
    logic signed [31:0] r;
    if ((&s[63:31]) || !(|s[63:31])) begin
      r = s[31:0];
    end else begin
      r = {s[63], {31{~s[63]}}};
    end
    return r;
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Unpack the input vector and form the force sums
  always_comb begin
    vec_in[0] = in_data.vec_x;
    vec_in[1] = in_data.vec_y;
    vec_in[2] = in_data.vec_z;
    for (int i = 0; i < 3; i++) begin
      force_add[i] = sat33(33'(force_sum[i]) + 33'(vec_in[i]));
    end
  end

  // Select the base acceleration of the current axis
  always_comb begin
    unique case (ax)
      2'd1:    base_sel = base_accel_y;
      2'd2:    base_sel = base_accel_z;
      default: base_sel = base_accel_x;
    endcase
  end

  // Route operands to the shared multiplier
  always_comb begin
    unique case (state)
      S_POS_FORCE: begin
        mul_a = force_sum[ax];
        mul_b = inv_mass;
      end
      S_MUL_DAMP: begin
        mul_a = tmp;
        mul_b = {14'd0, damping_per_step};
      end
      S_MUL_ACC: begin
        mul_a = tmp;
        mul_b = time_step;
      end
      default: begin
        mul_a = vel_vec[ax];
        mul_b = time_step;
      end
    endcase
  end

  assign mul_p      = mul_a * $signed({1'b0, mul_b});
  assign prod_shift = prod >>> FRAC_BITS;
  assign q_sat      = sat64(prod_shift);

  // Route operands to the shared saturating adder
  always_comb begin
    unique case (state)
      S_POS_FORCE: add_a = pos_vec[ax];
      S_ACC:       add_a = base_sel;
      default:     add_a = vel_vec[ax];
    endcase
  end

  assign sum_sat = sat33(33'(add_a) + 33'(q_sat));

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      ax               <= 2'd0;
      out_valid        <= 1'b0;
      inv_mass         <= RST_INV_MASS;
      base_accel_x     <= '0;
      base_accel_y     <= RST_ACCEL_Y;
      base_accel_z     <= '0;
      time_step        <= RST_STEP;
      damping_per_step <= RST_DAMP;
      active           <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_vec[i]   <= '0;
        vel_vec[i]   <= '0;
        force_sum[i] <= '0;
      end
    end else begin
      // Drop a result once it is taken, unless the next one loads now
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      // Register writes; the user must keep the block idle whenever they come, which the block does not enforce
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INV_MASS:     inv_mass <= cfg_data[30:0];
          CFG_BASE_ACCEL_X: base_accel_x <= cfg_data;
          CFG_BASE_ACCEL_Y: base_accel_y <= cfg_data;
          CFG_BASE_ACCEL_Z: base_accel_z <= cfg_data;
          CFG_TIME_STEP:    time_step <= cfg_data[30:0];
          CFG_DAMPING:      damping_per_step <= cfg_data[16:0];
          CFG_ACTIVE: begin
            active <= cfg_data[0];
            if (cfg_data[0]) begin
              for (int i = 0; i < 3; i++) begin
                force_sum[i] <= '0;
              end
            end
          end
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= ((in_data.kind == KIND_STEP) && active && (inv_mass != '0)) ?
                     S_MUL_VEL : S_OUT;
            ax    <= 2'd0;
            unique case (in_data.kind)
              KIND_FORCE: begin
                for (int i = 0; i < 3; i++) begin
                  force_sum[i] <= force_add[i];
                end
              end
              KIND_SET_POS: begin
                for (int i = 0; i < 3; i++) begin
                  pos_vec[i] <= vec_in[i];
                end
              end
              KIND_SET_VEL: begin
                for (int i = 0; i < 3; i++) begin
                  vel_vec[i] <= vec_in[i];
                end
              end
              KIND_STEP: ;
            endcase
          end
        end
        // vel * dt
        S_MUL_VEL: begin
          prod  <= mul_p;
          state <= S_POS_FORCE;
        end
        // advance position; force * inv_mass
        S_POS_FORCE: begin
          pos_vec[ax] <= sum_sat;
          prod        <= mul_p;
          state       <= S_ACC;
        end
        // acceleration = base + force * inv_mass
        S_ACC: begin
          tmp   <= sum_sat;
          state <= S_MUL_ACC;
        end
        // acc * dt
        S_MUL_ACC: begin
          prod  <= mul_p;
          state <= S_VEL;
        end
        // undamped velocity
        S_VEL: begin
          tmp   <= sum_sat;
          state <= S_MUL_DAMP;
        end
        // velocity * damping
        S_MUL_DAMP: begin
          prod  <= mul_p;
          state <= S_DAMP;
        end
        // store damped velocity, clear force, next axis
        S_DAMP: begin
          vel_vec[ax]   <= q_sat;
          force_sum[ax] <= '0;
          if (ax == 2'd2) begin
            ax    <= 2'd0;
            state <= S_OUT;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_MUL_VEL;
          end
        end
        // hold until the output register is free
        S_OUT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_data.pos_x <= pos_vec[0];
            out_data.pos_y <= pos_vec[1];
            out_data.pos_z <= pos_vec[2];
            out_data.vel_x <= vel_vec[0];
            out_data.vel_y <= vel_vec[1];
            out_data.vel_z <= vel_vec[2];
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Axis counter never leaves the three axes
  assert property (@(posedge clk) disable iff (rst) ax != 2'd3)
    else $error("axis counter out of range");

  // The last axis ends the step and goes to the result
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DAMP && ax == 2'd2) |=> (state == S_OUT))
    else $error("step did not finish after the last axis");

  // A completed step leaves the force sum cleared
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DAMP && ax == 2'd2) |=>
      (force_sum[0] == '0 && force_sum[1] == '0 && force_sum[2] == '0))
    else $error("force sum not cleared by step");

  // Items other than a live step go straight to the result
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_data.kind != KIND_STEP || !active || inv_mass == '0))
      |=> (state == S_OUT))
    else $error("short item entered the step sequence");

  // A result is only loaded from the result state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the result state");

endmodule

[test/damped_particle_integrator_unit_test.sv]
// ----------------------------------------------------------------------------
// damped_particle_integrator_unit_test: self-checking bench for the integrator
// Drives force, step and load transactions with random gaps and output
// stalls, runs a fixed-point Euler model beside the block under several
// register settings, and compares every result field with the model.
// ----------------------------------------------------------------------------
module damped_particle_integrator_unit_test
  import dpint_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEFAULT;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 150;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  damped_particle_integrator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Particle model: registers and state
  logic [30:0]        m_inv_mass = 31'(Q16_ONE);
  logic signed [31:0] m_accel [3] = '{32'sd0, -32'(Q16_GRAVITY), 32'sd0};
  logic [30:0]        m_step = 31'(Q16_STEP);
  logic [16:0]        m_damp = 17'(Q16_DAMP);
  logic               m_active = 1'b0;
  logic signed [31:0] m_pos [3] = '{default: 0};
  logic signed [31:0] m_vel [3] = '{default: 0};
  logic signed [31:0] m_force [3] = '{default: 0};

  in_item_t  pending_items[$];
  out_item_t expected_states[$];

  string field_name [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

  bit calm = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int errors = 0;
  int results_checked = 0;
  int kind_count [4] = '{default: 0};
  int live_steps = 0;
  int settings_run = 0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  // Fixed-point product, floor of the shifted value, saturated
  function automatic logic signed [31:0] fix_mul(logic signed [31:0] a, longint b);
    longint prod;
    prod = longint'(a) * b;
    return clamp32(prod >>> FRAC);
  endfunction

  // Apply one accepted transaction to the model and queue the resulting state
  task automatic advance_particle(in_item_t it);
    logic signed [31:0] v [3];
    logic signed [31:0] vel_old;
    logic signed [31:0] acc;
    logic signed [31:0] vel_new;
    v = '{it.vec_x, it.vec_y, it.vec_z};
    kind_count[it.kind]++;
    case (it.kind)
      KIND_FORCE: begin
        for (int i = 0; i < 3; i++) m_force[i] = clamp32(longint'(m_force[i]) + longint'(v[i]));
      end
      KIND_SET_POS: m_pos = v;
      KIND_SET_VEL: m_vel = v;
      default: begin
        // Inactive or immovable: leave everything, force sum too
        if (m_active && m_inv_mass != 0) begin
          live_steps++;
          for (int i = 0; i < 3; i++) begin
            vel_old  = m_vel[i];
            m_pos[i] = clamp32(longint'(m_pos[i]) + longint'(fix_mul(vel_old, m_step)));
            acc      = clamp32(longint'(m_accel[i]) + longint'(fix_mul(m_force[i], m_inv_mass)));
            vel_new  = clamp32(longint'(vel_old) + longint'(fix_mul(acc, m_step)));
            m_vel[i] = fix_mul(vel_new, m_damp);
            m_force[i] = 0;
          end
        end
      end
    endcase
    expected_states.push_back(out_item_t'{pos_x: m_pos[0], pos_y: m_pos[1], pos_z: m_pos[2],
                                          vel_x: m_vel[0], vel_y: m_vel[1], vel_z: m_vel[2]});
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_states.size() == 0) begin
      report_mismatch($sformatf("result %h with no transaction pending", got));
      return;
    end
    want = expected_states.pop_front();
    for (int f = 0; f < 6; f++) begin
      if (got[32*(5-f) +: 32] !== want[32*(5-f) +: 32]) begin
        report_mismatch($sformatf("result %0d %s got %h want %h", results_checked,
                                  field_name[f], got[32*(5-f) +: 32], want[32*(5-f) +: 32]));
      end
    end
    results_checked++;
  endtask

  // Driver: accept, then hold off for the drawn gap before the next item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_particle(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_items.size() > 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          gap_left = calm ? 0 : $urandom_range(0, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result, then stall the next one for a drawn count
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        stall_left = calm ? 0 : $urandom_range(0, 10);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Write one register and mirror it in the model; block is idle here
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_INV_MASS:     m_inv_mass = data[30:0];
      CFG_BASE_ACCEL_X: m_accel[0] = data;
      CFG_BASE_ACCEL_Y: m_accel[1] = data;
      CFG_BASE_ACCEL_Z: m_accel[2] = data;
      CFG_TIME_STEP:    m_step = data[30:0];
      CFG_DAMPING:      m_damp = data[16:0];
      CFG_ACTIVE: begin
        m_active = data[0];
        if (data[0]) m_force = '{default: 0};
      end
      default: ;
    endcase
  endtask

  task automatic queue_item(kind_t k, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    pending_items.push_back(in_item_t'{kind: k, vec_x: x, vec_y: y, vec_z: z});
  endtask

  // Wait until every queued transaction has been sent and answered
  task automatic drain();
    @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_states.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_component();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return int'($urandom_range(0, 2097152)) - 1048576;
    if (sel < 85) return $urandom();
    case ($urandom_range(0, 4))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  initial begin : stimulus
    int n;
    int sel;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0] value;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, particle inactive: steps hold, forces still add and saturate
    settings_run++;
    queue_item(KIND_STEP, 32'sd0, 32'sd0, 32'sd0);
    queue_item(KIND_FORCE, Q_MAX, Q_MIN, 32'sd1);
    queue_item(KIND_FORCE, Q_MAX, Q_MIN, -32'sd1);
    queue_item(KIND_SET_POS, Q_MIN, Q_MAX, 32'sd0);
    queue_item(KIND_SET_VEL, Q_MAX, Q_MIN, 32'sd12345);
    queue_item(KIND_STEP, 32'sd0, 32'sd0, 32'sd0);
    drain();

    // Activate: clears the held force; plain steps, then saturating ones
    settings_run++;
    write_reg(CFG_ACTIVE, 32'd1);
    queue_item(KIND_SET_POS, 32'sd0, 32'sd0, 32'sd0);
    queue_item(KIND_SET_VEL, 32'sd65536, -32'sd131072, 32'sd0);
    queue_item(KIND_FORCE, 32'sd65536, -32'sd131072, 32'sd32768);
    queue_item(KIND_STEP, 32'sd0, 32'sd0, 32'sd0);
    queue_item(KIND_STEP, Q_MAX, Q_MAX, Q_MAX);
    queue_item(KIND_FORCE, Q_MAX, Q_MIN, Q_MAX);
    queue_item(KIND_STEP, 32'sd0, 32'sd0, 32'sd0);
    drain();

    // Immovable: step holds state and force
    settings_run++;
    write_reg(CFG_INV_MASS, 32'd0);
    queue_item(KIND_FORCE, 32'sd1000, -32'sd1000, 32'sd7);
    queue_item(KIND_STEP, 32'sd0, 32'sd0, 32'sd0);
    drain();

    // Re-activate while active clears force; extreme registers, damping above one
    settings_run++;
    write_reg(CFG_ACTIVE, 32'd1);
    write_reg(CFG_INV_MASS, 32'hFFFF_FFFF);
    write_reg(CFG_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_DAMPING, 32'hFFFF_FFFF);
    write_reg(CFG_BASE_ACCEL_X, Q_MAX);
    write_reg(CFG_BASE_ACCEL_Y, Q_MIN);
    write_reg(CFG_BASE_ACCEL_Z, 32'h0001_0000);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    queue_item(KIND_STEP, 32'sd0, 32'sd0, 32'sd0);
    queue_item(KIND_SET_VEL, 32'sd100, -32'sd100, 32'sd0);
    queue_item(KIND_FORCE, -32'sd5, 32'sd5, Q_MIN);
    queue_item(KIND_STEP, 32'sd0, 32'sd0, 32'sd0);
    queue_item(KIND_STEP, 32'sd0, 32'sd0, 32'sd0);
    drain();

    // Zero damping and zero step
    settings_run++;
    write_reg(CFG_DAMPING, 32'd0);
    write_reg(CFG_TIME_STEP, 32'd0);
    queue_item(KIND_SET_VEL, Q_MAX, Q_MIN, 32'sd99);
    queue_item(KIND_STEP, 32'sd0, 32'sd0, 32'sd0);
    drain();

    // Random settings and random frames of forces followed by a step, with loads and random items mixed in
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settings_run++;
      calm = (ph % 4 == 3);
      for (int r = 0; r <= int'(CFG_ACTIVE); r++) begin
        idx = CFG_IDX_W'(r);
        sel = $urandom_range(0, 9);
        case (idx)
          CFG_INV_MASS:
            value = (sel == 0) ? 32'd0 : (sel == 1) ? 32'h7FFF_FFFF : (sel == 2) ? $urandom() :
                    (sel < 5) ? 32'(Q16_ONE) : $urandom_range(0, 262144);
          CFG_TIME_STEP:
            value = (sel == 0) ? 32'd0 : (sel == 1) ? 32'h7FFF_FFFF : (sel == 2) ? $urandom() :
                    (sel < 5) ? 32'(Q16_STEP) : $urandom_range(1, 65536);
          CFG_DAMPING:
            value = (sel == 0) ? 32'd0 : (sel == 1) ? 32'h1_FFFF : (sel == 2) ? 32'h1_0000 :
                    (sel == 3) ? $urandom() : (sel == 4) ? 32'(Q16_DAMP) :
                    $urandom_range(60000, 65536);
          CFG_ACTIVE:
            value = (sel != 0) ? 32'd1 : 32'd0;
          default:
            value = (sel == 0) ? 32'd0 : (sel == 1) ? Q_MIN : (sel == 2) ? Q_MAX :
                    (sel == 3) ? $urandom() : 32'(int'($urandom_range(0, 4194304)) - 2097152);
        endcase
        write_reg(idx, value);
      end
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom());

      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
          repeat ($urandom_range(0, 3)) begin
            queue_item(KIND_FORCE, rand_component(), rand_component(), rand_component());
            n++;
          end
          queue_item(KIND_STEP, $urandom(), $urandom(), $urandom());
          n++;
        end else if (sel < 82) begin
          queue_item(KIND_SET_POS, rand_component(), rand_component(), rand_component());
          n++;
        end else if (sel < 89) begin
          queue_item(KIND_SET_VEL, rand_component(), rand_component(), rand_component());
          n++;
        end else begin
          queue_item(kind_t'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
          n++;
        end
      end
      drain();
    end

    // Final settle, then report
    calm = 1'b0;
    repeat (30) @(posedge clk);
    $display("Covered %0d forces, %0d steps (%0d moving), %0d position and %0d velocity loads",
             kind_count[KIND_FORCE], kind_count[KIND_STEP], live_steps,
             kind_count[KIND_SET_POS], kind_count[KIND_SET_VEL]);
    $display("over %0d register settings; %0d results compared, %0d mismatches",
             settings_run, results_checked, errors);
    if (errors == 0 && expected_states.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/dpint_pkg.sv
hdl/damped_particle_integrator_unit.sv
test/damped_particle_integrator_unit_test.sv
